### sv/otk_pkg.sv
// Package with the token types, character constants and classification helpers of the tokenizer.
`timescale 1ns / 1ps

package otk_pkg;

   localparam int VALUE_WIDTH = 32;

   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharMinus   = 8'h2D;
   localparam logic [7:0] CharAmp     = 8'h26;
   localparam logic [7:0] CharPipe    = 8'h7C;
   localparam logic [7:0] CharStar    = 8'h2A;
   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharCaret   = 8'h5E;
   localparam logic [7:0] CharOParen  = 8'h28;
   localparam logic [7:0] CharCParen  = 8'h29;
   localparam logic [7:0] CharBang    = 8'h21;
   localparam logic [7:0] CharTilde   = 8'h7E;
   localparam logic [7:0] CharSemi    = 8'h3B;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharTab     = 8'h09;
   localparam logic [7:0] CharCr      = 8'h0D;

   typedef enum logic [4:0] {
      KIND_EOF        = 5'd0,
      KIND_PLUSPLUS   = 5'd1,
      KIND_PLUS       = 5'd2,
      KIND_MINUSMINUS = 5'd3,
      KIND_MINUS      = 5'd4,
      KIND_STAR       = 5'd5,
      KIND_SLASH      = 5'd6,
      KIND_PERCENT    = 5'd7,
      KIND_HELM       = 5'd8,
      KIND_AMPS       = 5'd9,
      KIND_AMP        = 5'd10,
      KIND_PIPES      = 5'd11,
      KIND_PIPE       = 5'd12,
      KIND_OPAREN     = 5'd13,
      KIND_CPAREN     = 5'd14,
      KIND_BANG       = 5'd15,
      KIND_TILDA      = 5'd16,
      KIND_SEMI       = 5'd17,
      KIND_LINT       = 5'd18,
      KIND_BAD        = 5'd19
   } kind_type;

   typedef enum logic [2:0] {
      PEND_NONE  = 3'd0,
      PEND_PLUS  = 3'd1,
      PEND_MINUS = 3'd2,
      PEND_AMP   = 3'd3,
      PEND_PIPE  = 3'd4
   } pend_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             tchar;
      logic [VALUE_WIDTH-1:0] value;
      logic                   last;
   } token_type;

   typedef struct packed {
      pend_type               pend;
      logic                   in_number;
      logic [VALUE_WIDTH-1:0] acc;
   } state_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CharZero) && (b <= CharNine);
   endfunction

   function automatic logic pend_active(input pend_type p);
      return (p == PEND_PLUS) || (p == PEND_MINUS) || (p == PEND_AMP) || (p == PEND_PIPE);
   endfunction

   function automatic logic [7:0] pend_char(input pend_type p);
      logic [7:0] c;
      unique case (p)
         PEND_PLUS:  c = CharPlus;
         PEND_MINUS: c = CharMinus;
         PEND_AMP:   c = CharAmp;
         PEND_PIPE:  c = CharPipe;
         default:    c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic kind_type pend_single(input pend_type p);
      kind_type k;
      unique case (p)
         PEND_PLUS:  k = KIND_PLUS;
         PEND_MINUS: k = KIND_MINUS;
         PEND_AMP:   k = KIND_AMP;
         PEND_PIPE:  k = KIND_PIPE;
         default:    k = KIND_BAD;
      endcase
      return k;
   endfunction

   function automatic kind_type pend_double(input pend_type p);
      kind_type k;
      unique case (p)
         PEND_PLUS:  k = KIND_PLUSPLUS;
         PEND_MINUS: k = KIND_MINUSMINUS;
         PEND_AMP:   k = KIND_AMPS;
         PEND_PIPE:  k = KIND_PIPES;
         default:    k = KIND_BAD;
      endcase
      return k;
   endfunction

   function automatic pend_type pend_of(input logic [7:0] b);
      pend_type p;
      unique case (b)
         CharPlus:  p = PEND_PLUS;
         CharMinus: p = PEND_MINUS;
         CharAmp:   p = PEND_AMP;
         CharPipe:  p = PEND_PIPE;
         default:   p = PEND_NONE;
      endcase
      return p;
   endfunction

   function automatic kind_type single_kind(input logic [7:0] b);
      kind_type k;
      unique case (b)
         CharStar:    k = KIND_STAR;
         CharSlash:   k = KIND_SLASH;
         CharPercent: k = KIND_PERCENT;
         CharCaret:   k = KIND_HELM;
         CharOParen:  k = KIND_OPAREN;
         CharCParen:  k = KIND_CPAREN;
         CharBang:    k = KIND_BANG;
         CharTilde:   k = KIND_TILDA;
         CharSemi:    k = KIND_SEMI;
         default:     k = KIND_BAD;
      endcase
      return k;
   endfunction

endpackage

### sv/otk_step.sv
// Combinational next-state and token logic for one source byte of the tokenizer.
`timescale 1ns / 1ps

module otk_step (
   input  otk_pkg::state_type  cur_state,
   input  logic [7:0]          source_byte,
   input  logic                at_end,
   output otk_pkg::state_type  next_state,
   output otk_pkg::result_type result
);
   import otk_pkg::*;

   token_type               flush_tok;
   logic                    flush_valid;
   token_type               fresh_tok;
   logic                    fresh_valid;
   token_type               first_tok;
   token_type               second_tok;
   logic                    first_valid;
   logic                    second_valid;
   logic [VALUE_WIDTH-1:0]  digit_val;
   logic [VALUE_WIDTH-1:0]  acc_times_ten;

   assign digit_val     = VALUE_WIDTH'(source_byte - CharZero);
   assign acc_times_ten = {cur_state.acc[VALUE_WIDTH-4:0], 3'b000}
                        + {cur_state.acc[VALUE_WIDTH-2:0], 1'b0};

   always_comb begin
      flush_tok   = '0;
      flush_valid = 1'b0;
      if (pend_active(cur_state.pend)) begin
         flush_valid     = 1'b1;
         flush_tok.kind  = pend_single(cur_state.pend);
         flush_tok.tchar = pend_char(cur_state.pend);
      end else if (cur_state.in_number) begin
         flush_valid     = 1'b1;
         flush_tok.kind  = KIND_LINT;
         flush_tok.value = cur_state.acc;
      end
   end

   always_comb begin
      fresh_tok   = '0;
      fresh_valid = 1'b0;
      if (!is_space(source_byte) && !is_digit(source_byte)
          && (pend_of(source_byte) == PEND_NONE)) begin
         fresh_valid     = 1'b1;
         fresh_tok.kind  = single_kind(source_byte);
         fresh_tok.tchar = source_byte;
      end
   end

   always_comb begin
      next_state   = cur_state;
      first_tok    = '0;
      second_tok   = '0;
      first_valid  = 1'b0;
      second_valid = 1'b0;
      priority if (at_end) begin
         next_state      = '0;
         first_tok       = flush_tok;
         first_valid     = flush_valid;
         second_tok      = '0;
         second_tok.kind = KIND_EOF;
         second_valid    = 1'b1;
      end else if (pend_active(cur_state.pend)
                   && (source_byte == pend_char(cur_state.pend))) begin
         next_state.pend = PEND_NONE;
         first_tok.kind  = pend_double(cur_state.pend);
         first_valid     = 1'b1;
      end else if (cur_state.in_number && is_digit(source_byte)) begin
         next_state.acc = acc_times_ten + digit_val;
      end else begin
         next_state.pend      = pend_of(source_byte);
         next_state.in_number = is_digit(source_byte);
         next_state.acc       = is_digit(source_byte) ? digit_val : '0;
         first_tok            = flush_tok;
         first_valid          = flush_valid;
         second_tok           = fresh_tok;
         second_valid         = fresh_valid;
      end
   end

   always_comb begin
      result       = '0;
      result.count = {1'b0, first_valid} + {1'b0, second_valid};
      if (first_valid) begin
         result.tok0      = first_tok;
         result.tok0.last = !second_valid;
         result.tok1      = second_tok;
         result.tok1.last = 1'b1;
      end else begin
         result.tok0      = second_tok;
         result.tok0.last = 1'b1;
      end
   end

endmodule

### sv/operator_integer_tokenizer.sv
// Top level of the tokenizer: state registers, step logic and a two-entry result buffer.
`timescale 1ns / 1ps
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_source_byte, req_at_end
//   rsp      out        rsp_valid / rsp_ready  rsp_token_kind, rsp_token_char,
//                                              rsp_literal_value, rsp_last_of_run
//
// A byte is taken when req_valid and req_ready are both high; its tokens appear at the
// output on the next cycle. After a byte with no token the input stays ready, after one
// with one token it is ready while rsp_ready is high, and a byte with two tokens holds
// off the input while the result buffer drains. Reset is synchronous and returns the tokenizer
// to no pending operator and no number. A stalled result port holds the input off.

module operator_integer_tokenizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_source_byte,
   input  logic                            req_at_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [4:0]                      rsp_token_kind,
   output logic [7:0]                      rsp_token_char,
   output logic [otk_pkg::VALUE_WIDTH-1:0] rsp_literal_value,
   output logic                            rsp_last_of_run
);
   import otk_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   state_type  step_state;
   result_type step_result;
   token_type  slot0_ff;
   token_type  slot0_in;
   token_type  slot1_ff;
   token_type  slot1_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   otk_step u_step (
      .cur_state   (state_ff),
      .source_byte (req_source_byte),
      .at_end      (req_at_end),
      .next_state  (step_state),
      .result      (step_result)
   );

   assign rsp_valid = (count_ff != 2'd0);
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_token_kind    = slot0_ff.kind;
   assign rsp_token_char    = slot0_ff.tchar;
   assign rsp_literal_value = slot0_ff.value;
   assign rsp_last_of_run   = slot0_ff.last;

   always_comb begin
      priority if (push) begin
         state_in = step_state;
         count_in = step_result.count;
         slot0_in = step_result.tok0;
         slot1_in = step_result.tok1;
      end else if (pop) begin
         state_in = state_ff;
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
         slot1_in = slot1_ff;
      end else begin
         state_in = state_ff;
         count_in = count_ff;
         slot0_in = slot0_ff;
         slot1_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

### sv/otk_checker.sv
// Port-level assertions for the tokenizer and the bind that attaches them.
`timescale 1ns / 1ps

module otk_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [4:0]                      rsp_token_kind,
   input logic [7:0]                      rsp_token_char,
   input logic [otk_pkg::VALUE_WIDTH-1:0] rsp_literal_value,
   input logic                            rsp_last_of_run
);
   import otk_pkg::*;

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_token_char) && $stable(rsp_literal_value)
         && $stable(rsp_last_of_run))
      else $error("result transaction changed while stalled");

   // The first of two tokens from one byte blocks new input until it leaves.
   a_pair_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input accepted while a token pair is pending");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_EOF) |-> rsp_last_of_run
         && (rsp_token_char == 8'h00) && (rsp_literal_value == '0))
      else $error("EOF token is not the clean last token of its transaction");

   a_value_only_lint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != KIND_LINT) |-> (rsp_literal_value == '0))
      else $error("literal value on a non-integer token");

   a_no_char_on_multi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_token_kind == KIND_PLUSPLUS) || (rsp_token_kind == KIND_MINUSMINUS)
         || (rsp_token_kind == KIND_AMPS) || (rsp_token_kind == KIND_PIPES)
         || (rsp_token_kind == KIND_LINT)) |-> (rsp_token_char == 8'h00))
      else $error("character on a doubled or integer token");

endmodule

bind operator_integer_tokenizer otk_checker u_otk_checker (.*);

### tb/tb_operator_integer_tokenizer.sv
// Self-checking testbench for the operator and integer tokenizer.
`timescale 1ns / 1ps

module tb_operator_integer_tokenizer;
   import otk_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_source_byte = 8'h00;
   logic                   req_at_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [4:0]             rsp_token_kind;
   logic [7:0]             rsp_token_char;
   logic [VALUE_WIDTH-1:0] rsp_literal_value;
   logic                   rsp_last_of_run;

   localparam logic [7:0] OperatorChars [13] = '{CharPlus, CharMinus, CharAmp, CharPipe,
      CharStar, CharSlash, CharPercent, CharCaret, CharOParen, CharCParen, CharBang,
      CharTilde, CharSemi};
   localparam logic [7:0] BlankChars [6] = '{CharTab, 8'h0A, 8'h0B, 8'h0C, CharCr, CharSpace};

   token_type              awaited_tokens[$];
   pend_type               held_operator = PEND_NONE;
   logic                   number_open = 1'b0;
   logic [VALUE_WIDTH-1:0] number_so_far = '0;
   int                     mismatch_count = 0;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;

   operator_integer_tokenizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_byte   (req_source_byte),
      .req_at_end        (req_at_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_token_char    (rsp_token_char),
      .rsp_literal_value (rsp_literal_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CharSpace) || (b >= CharTab && b <= CharCr);
   endfunction

   function automatic logic is_decimal(input logic [7:0] b);
      return b >= CharZero && b <= CharNine;
   endfunction

   function automatic logic [7:0] held_char(input pend_type p);
      case (p)
         PEND_PLUS:  return CharPlus;
         PEND_MINUS: return CharMinus;
         PEND_AMP:   return CharAmp;
         PEND_PIPE:  return CharPipe;
         default:    return 8'h00;
      endcase
   endfunction

   function automatic kind_type held_kind(input pend_type p, input logic doubled);
      case (p)
         PEND_PLUS:  return doubled ? KIND_PLUSPLUS : KIND_PLUS;
         PEND_MINUS: return doubled ? KIND_MINUSMINUS : KIND_MINUS;
         PEND_AMP:   return doubled ? KIND_AMPS : KIND_AMP;
         default:    return doubled ? KIND_PIPES : KIND_PIPE;
      endcase
   endfunction

   function automatic pend_type operator_to_hold(input logic [7:0] b);
      case (b)
         CharPlus:  return PEND_PLUS;
         CharMinus: return PEND_MINUS;
         CharAmp:   return PEND_AMP;
         CharPipe:  return PEND_PIPE;
         default:   return PEND_NONE;
      endcase
   endfunction

   function automatic kind_type lone_kind(input logic [7:0] b);
      case (b)
         CharStar:    return KIND_STAR;
         CharSlash:   return KIND_SLASH;
         CharPercent: return KIND_PERCENT;
         CharCaret:   return KIND_HELM;
         CharOParen:  return KIND_OPAREN;
         CharCParen:  return KIND_CPAREN;
         CharBang:    return KIND_BANG;
         CharTilde:   return KIND_TILDA;
         CharSemi:    return KIND_SEMI;
         default:     return KIND_BAD;
      endcase
   endfunction

   task automatic await_token(input kind_type k, input logic [7:0] c,
                              input logic [VALUE_WIDTH-1:0] v);
      token_type t;
      t.kind  = k;
      t.tchar = c;
      t.value = v;
      t.last  = 1'b0;
      awaited_tokens.push_back(t);
   endtask

   task automatic flush_open_token();
      if (held_operator != PEND_NONE) begin
         await_token(held_kind(held_operator, 1'b0), held_char(held_operator), '0);
      end
      held_operator = PEND_NONE;
      if (number_open) begin
         await_token(KIND_LINT, 8'h00, number_so_far);
      end
      number_open   = 1'b0;
      number_so_far = '0;
   endtask

   task automatic tokenize_byte(input logic [7:0] b, input logic at_end);
      int base;
      base = awaited_tokens.size();
      if (at_end) begin
         flush_open_token();
         await_token(KIND_EOF, 8'h00, '0);
      end else if (held_operator != PEND_NONE && b == held_char(held_operator)) begin
         await_token(held_kind(held_operator, 1'b1), 8'h00, '0);
         held_operator = PEND_NONE;
      end else if (number_open && is_decimal(b)) begin
         number_so_far = number_so_far * 10 + VALUE_WIDTH'(b - CharZero);
      end else begin
         flush_open_token();
         if (is_decimal(b)) begin
            number_open   = 1'b1;
            number_so_far = VALUE_WIDTH'(b - CharZero);
         end else if (operator_to_hold(b) != PEND_NONE) begin
            held_operator = operator_to_hold(b);
         end else if (!is_blank(b)) begin
            await_token(lone_kind(b), b, '0);
         end
      end
      if (awaited_tokens.size() > base) begin
         awaited_tokens[awaited_tokens.size() - 1].last = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
   endtask

   task automatic check_token();
      token_type t;
      if (awaited_tokens.size() == 0) begin
         report_mismatch($sformatf("token kind %0d with no token awaited", rsp_token_kind));
      end else begin
         t = awaited_tokens.pop_front();
         if (rsp_token_kind != t.kind)
            report_mismatch($sformatf("kind %0d, awaited %s", rsp_token_kind, t.kind.name()));
         if (rsp_token_char != t.tchar)
            report_mismatch($sformatf("char %h, awaited %h", rsp_token_char, t.tchar));
         if (rsp_literal_value != t.value)
            report_mismatch($sformatf("value %0d, awaited %0d", rsp_literal_value, t.value));
         if (rsp_last_of_run != t.last)
            report_mismatch($sformatf("last %b, awaited %b", rsp_last_of_run, t.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tokenize_byte(req_source_byte, req_at_end);
         end
         if (rsp_valid && rsp_ready) begin
            check_token();
         end
      end
   end

   // Called and returns at a falling edge; valid stays high after the transaction.
   task automatic send_item(input logic [7:0] b, input logic at_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid       <= 1'b0;
         req_source_byte <= 8'($urandom);
         req_at_end      <= 1'($urandom);
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_source_byte <= b;
      req_at_end      <= at_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(s[i], 1'b0);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_tokens.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] random_source_byte();
      int r;
      r = $urandom_range(99);
      if (r < 35) return CharZero + 8'($urandom_range(9));
      if (r < 65) return OperatorChars[$urandom_range(12)];
      if (r < 80) return BlankChars[$urandom_range(5)];
      return 8'($urandom_range(255));
   endfunction

   task automatic test_operator_tokens();
      send_text("++--&&||+/-%^()!~*;");
   endtask

   task automatic test_literal_wrap_and_end();
      send_text("4294967296&");
      send_item(8'hFF, 1'b0);
      send_item(CharPipe, 1'b0);
      send_item(8'hA5, 1'b1);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_stream(input int num_items, input int idle_pct,
                                     input int stall);
      int sent;
      int r;
      int run;
      logic [7:0] b;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      sent          = 0;
      while (sent < num_items) begin
         r = $urandom_range(99);
         if (r < 4) begin
            send_item(8'($urandom), 1'b1);
            sent++;
         end else if (r < 14) begin
            b = OperatorChars[$urandom_range(3)];
            send_item(b, 1'b0);
            send_item(b, 1'b0);
            sent += 2;
         end else if (r < 17) begin
            run = $urandom_range(9, 12);
            repeat (run) send_item(CharZero + 8'($urandom_range(9)), 1'b0);
            sent += run;
         end else begin
            send_item(random_source_byte(), 1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_operator_tokens();
      test_literal_wrap_and_end();
      test_random_stream(430, 0, 0);
      wait_for_drain();
      test_random_stream(430, 55, 0);
      test_random_stream(430, 0, 55);
      wait_for_drain();
      test_random_stream(430, 35, 35);
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (awaited_tokens.size() != 0) begin
         report_mismatch($sformatf("%0d tokens never arrived", awaited_tokens.size()));
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

endmodule
